// ===== rtl/core/wsnw_pkg.sv =====
package wsnw_pkg;

    localparam int NumSegRegs   = 8;
    localparam int MaxSegDflt   = 8;
    localparam int RegW         = 41;
    localparam int MinW         = 11;
    localparam int SecW         = 20;
    localparam int DayW         = 3;
    localparam int IdxW         = 3;
    localparam int SecPerMin    = 60;
    localparam int SecPerDay    = 86400;
    localparam int DaysPerWeek  = 7;
    localparam logic [SecW-1:0] NoneSleep = 20'd3600;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEG,
        ST_DIV,
        ST_DAY,
        ST_CALC,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic seg_start;
        logic div_step;
        logic seg_eval;
        logic next_day;
        logic calc;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic seg_last;
        logic need_div;
        logic div_done;
        logic have;
        logic last_day;
    } t_status;

endpackage

// ===== rtl/core/wsnw_ctrl.sv =====
module wsnw_ctrl
    import wsnw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SEG;
                end
            end
            ST_SEG: begin
                o_cmd.seg_start = 1'b1;
                n_state = i_status.need_div ? ST_DIV : ST_DAY;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = ST_DAY;
                end
            end
            ST_DAY: begin
                o_cmd.seg_eval = 1'b1;
                if (i_status.seg_last) begin
                    if (i_status.have || i_status.last_day) begin
                        n_state = ST_CALC;
                    end else begin
                        o_cmd.next_day = 1'b1;
                        n_state = ST_SEG;
                    end
                end else begin
                    n_state = ST_SEG;
                end
            end
            ST_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = ST_OUT;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/wsnw_dp.sv =====
module wsnw_dp
    import wsnw_pkg::*;
#(
    parameter int MAX_SEGMENTS = MaxSegDflt
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [IdxW-1:0] i_cfg_idx,
    input  logic [RegW-1:0] i_cfg_data,
    input  logic [2:0]      i_wday,
    input  logic [MinW-1:0] i_min,
    input  logic [5:0]      i_sec,
    input  t_cmd            i_cmd,
    output t_status         o_status,
    output logic            o_found,
    output logic [DayW-1:0] o_day_offset,
    output logic [MinW-1:0] o_wake_minute,
    output logic [SecW-1:0] o_sleep_seconds
);

    localparam int SegLast = MAX_SEGMENTS - 1;

    logic [RegW-1:0] r_seg [NumSegRegs];
    logic [2:0]      r_day;
    logic [DayW-1:0] r_off;
    logic [IdxW-1:0] r_s;
    logic [MinW-1:0] r_min;
    logic [5:0]      r_sec;
    logic            r_have;
    logic [MinW-1:0] r_best;
    // shared restoring divider
    logic [MinW-1:0] r_quo, r_rem, r_dvd;
    logic [3:0]      r_cnt;
    logic            r_phase;   // 0: steps divide, 1: position divide
    logic [MinW-1:0] r_steps;

    logic [RegW-1:0] seg;
    logic            en, dayok;
    logic [MinW-1:0] st, en_m, iv;
    logic            ge, need_steps, need_pos;
    logic [MinW:0]   rem_sh;
    logic [MinW+1:0] trial;
    logic [MinW-1:0] quo_nx, rem_nx;

    logic [MinW-1:0] cand_c, steps_c, k_c;
    logic [MinW:0]   k_full;
    logic [21:0]     kiv;
    logic            cand_ok;

    logic signed [22:0] wake_s, now_s, diff_s;
    logic [SecW-1:0]    sleep_c;

    // segment field decode
    always_comb begin
        seg        = r_seg[r_s];
        en         = seg[0];
        dayok      = seg[4'd1 + {1'b0, r_day}];
        st         = seg[18:8];
        en_m       = seg[29:19];
        iv         = seg[40:30];
        ge         = en_m >= st;
        need_steps = (r_off == '0) && en && dayok && iv != '0 && ge;
        need_pos   = (r_off == '0) && en && dayok && iv != '0 && st <= r_min;
        rem_sh     = {r_rem, r_dvd[MinW-1]};
        trial      = {1'b0, rem_sh} - {2'b00, iv};
        quo_nx     = {r_quo[MinW-2:0], !trial[MinW+1]};
        rem_nx     = trial[MinW+1] ? rem_sh[MinW-1:0] : trial[MinW-1:0];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NumSegRegs; i++) r_seg[i] <= '0;
        end else if (i_cfg_we) begin
            r_seg[i_cfg_idx] <= i_cfg_data;
        end
    end

    // search datapath
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_day  <= (i_wday == 3'd7) ? 3'd0 : i_wday;
            r_off  <= '0;
            r_s    <= '0;
            r_min  <= i_min;
            r_sec  <= i_sec;
            r_have <= 1'b0;
            r_best <= '0;
        end
        if (i_cmd.seg_start) begin
            r_phase <= !need_steps;
            r_dvd   <= need_steps ? en_m - st : r_min - st;
            r_rem   <= '0;
            r_quo   <= '0;
            r_cnt   <= '0;
            r_steps <= '0;
        end
        if (i_cmd.div_step) begin
            if (r_cnt == 4'(MinW - 1) && !r_phase && need_pos) begin
                r_steps <= quo_nx;
                r_phase <= 1'b1;
                r_dvd   <= r_min - st;
                r_rem   <= '0;
                r_quo   <= '0;
                r_cnt   <= '0;
            end else begin
                r_dvd <= {r_dvd[MinW-2:0], 1'b0};
                r_rem <= rem_nx;
                r_quo <= quo_nx;
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'(MinW - 1) && !r_phase) begin
                    r_steps <= quo_nx;
                end
            end
        end
        if (i_cmd.seg_eval) begin
            if (cand_ok && (!r_have || cand_c < r_best)) begin
                r_best <= cand_c;
                r_have <= 1'b1;
            end
            r_s <= (r_s == IdxW'(SegLast)) ? '0 : r_s + 1'b1;
            if (i_cmd.next_day) begin
                r_off <= r_off + 1'b1;
                r_day <= (r_day == 3'(DaysPerWeek - 1)) ? 3'd0 : r_day + 3'd1;
            end
        end
        if (i_cmd.calc) begin
            o_found         <= r_have;
            o_day_offset    <= r_have ? r_off : '0;
            o_wake_minute   <= r_have ? r_best : '0;
            o_sleep_seconds <= r_have ? sleep_c : NoneSleep;
        end
    end

    // candidate for current segment (quotient valid after the divides)
    always_comb begin
        steps_c = (iv == '0 || !ge) ? '0 : r_steps;
        k_full  = (st > r_min) ? '0 : ({1'b0, r_quo} + 12'd1);
        k_c     = k_full[MinW-1:0];
        kiv     = 22'(k_c) * 22'(iv);
        cand_c  = (r_off == '0) ? MinW'({11'd0, st} + kiv) : st;
        cand_ok = en && dayok;
        if (r_off == '0) begin
            if (iv != '0 && !ge && (st - en_m) >= iv) cand_ok = 1'b0;
            if (st <= r_min && iv == '0) cand_ok = 1'b0;
            if (k_full > {1'b0, steps_c}) cand_ok = 1'b0;
        end
    end

    // sleep seconds
    always_comb begin
        wake_s  = 23'(r_off) * 23'(SecPerDay) + 23'(r_best) * 23'(SecPerMin);
        now_s   = 23'(r_min) * 23'(SecPerMin) + 23'(r_sec);
        diff_s  = wake_s - now_s;
        sleep_c = diff_s[22] ? '0 : diff_s[SecW-1:0];
    end

    always_comb begin
        o_status.seg_last = (r_s == IdxW'(SegLast));
        o_status.need_div = need_steps || need_pos;
        o_status.div_done = (r_cnt == 4'(MinW - 1)) && (r_phase || !need_pos);
        o_status.have     = r_have || (cand_ok && i_cmd.seg_eval);
        o_status.last_day = (r_off == 3'd7);
    end

endmodule

// ===== rtl/core/weekly_schedule_next_wakeup_core.sv =====
// weekly schedule next-wakeup search
// input channel i_in_valid/o_in_ready carries one request: weekday, minute,
// second. output channel o_out_valid/i_out_ready returns found, day offset,
// wake minute and sleep seconds for that request.
// segment registers are written through i_cfg_we/i_cfg_idx/i_cfg_data; the
// user must do so only while the block is idle, which the block itself does
// not enforce. writes to indexes beyond the last segment are stored but not
// searched. one request is handled at a time. the controller walks up to
// eight days by MAX_SEGMENTS segments, each through a start and an evaluate
// state; segments checked today may also use the shared bit-serial divider.
// the result is held in output registers until taken; a stalled receiver
// simply holds the block in its output state, and no new request is taken.
// synchronous reset clears the segment registers and returns to idle.
module weekly_schedule_next_wakeup_core
    import wsnw_pkg::*;
#(
    parameter int MAX_SEGMENTS = MaxSegDflt
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [IdxW-1:0] i_cfg_idx,
    input  logic [RegW-1:0] i_cfg_data,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [2:0]      i_current_weekday,
    input  logic [MinW-1:0] i_current_minute,
    input  logic [5:0]      i_current_second,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic            o_found,
    output logic [DayW-1:0] o_day_offset,
    output logic [MinW-1:0] o_wake_minute,
    output logic [SecW-1:0] o_sleep_seconds
);

    t_cmd    cmd;
    t_status status;

    wsnw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    wsnw_dp #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_wday          (i_current_weekday),
        .i_min           (i_current_minute),
        .i_sec           (i_current_second),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_found         (o_found),
        .o_day_offset    (o_day_offset),
        .o_wake_minute   (o_wake_minute),
        .o_sleep_seconds (o_sleep_seconds)
    );

endmodule

// ===== rtl/core/wsnw_checker.sv =====
module wsnw_checker
    import wsnw_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_ready,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input logic            o_found,
    input logic [DayW-1:0] o_day_offset,
    input logic [MinW-1:0] o_wake_minute,
    input logic [SecW-1:0] o_sleep_seconds
);

    // never ready for input while a result is shown
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready while result pending");

    // a result is never shown the cycle after a request is taken
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_out_valid) else $error("result too early");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_sleep_seconds)
        && $stable(o_found))) else $error("result changed while stalled");

    // nothing found gives the default sleep
    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_sleep_seconds == NoneSleep
        && o_day_offset == '0 && o_wake_minute == '0)) else $error("bad empty result");

endmodule

bind weekly_schedule_next_wakeup_core wsnw_checker u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_found         (o_found),
    .o_day_offset    (o_day_offset),
    .o_wake_minute   (o_wake_minute),
    .o_sleep_seconds (o_sleep_seconds)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import wsnw_pkg::*;

    typedef struct packed {
        logic            found;
        logic [DayW-1:0] day;
        logic [MinW-1:0] minute;
        logic [SecW-1:0] sleep;
    } t_wake;

    localparam int unsigned CycleLimit = 3000000;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_cfg_we;
    logic [IdxW-1:0] i_cfg_idx;
    logic [RegW-1:0] i_cfg_data;
    logic            i_in_valid;
    logic            o_in_ready;
    logic [2:0]      i_current_weekday;
    logic [MinW-1:0] i_current_minute;
    logic [5:0]      i_current_second;
    logic            o_out_valid;
    logic            i_out_ready;
    logic            o_found;
    logic [DayW-1:0] o_day_offset;
    logic [MinW-1:0] o_wake_minute;
    logic [SecW-1:0] o_sleep_seconds;

    logic [RegW-1:0] sched_regs [NumSegRegs];
    t_wake           wake_q [$];
    int unsigned     mismatches;
    int unsigned     requests_sent;
    int unsigned     results_seen;
    int unsigned     found_seen;
    int unsigned     cycles;
    int unsigned     stall_left;
    bit              calm;

    weekly_schedule_next_wakeup_core dut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run guard
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb NOT OK");
            $finish;
        end
    end

    // earliest time today strictly after cur, per segment
    function automatic bit pick_today(int unsigned st, int unsigned en, int unsigned iv,
                                      int unsigned cur, output int unsigned pick);
        int unsigned steps;
        int unsigned k;
        pick = 0;
        if (iv == 0) steps = 0;
        else if (en >= st) steps = (en - st) / iv;
        else if (st - en < iv) steps = 0;
        else return 1'b0;
        if (st > cur) k = 0;
        else if (iv == 0) return 1'b0;
        else k = (cur - st) / iv + 1;
        if (k > steps) return 1'b0;
        pick = st + k * iv;
        return 1'b1;
    endfunction

    function automatic t_wake predict_wakeup(logic [2:0] wd, logic [MinW-1:0] mn,
                                             logic [5:0] sc);
        t_wake       res;
        int unsigned day;
        int unsigned best;
        int unsigned cand;
        longint      delta;
        bit          have;
        logic [RegW-1:0] r;
        res = '{found: 1'b0, day: '0, minute: '0, sleep: NoneSleep};
        for (int off = 0; off <= 7; off++) begin
            day = (wd + off) % DaysPerWeek;
            have = 1'b0;
            best = 0;
            for (int s = 0; s < NumSegRegs; s++) begin
                r = sched_regs[s];
                if (!r[0] || !r[1 + day]) continue;
                if (off == 0) begin
                    if (!pick_today(32'(r[18:8]), 32'(r[29:19]), 32'(r[40:30]),
                                    32'(mn), cand)) continue;
                end else begin
                    cand = 32'(r[18:8]);
                end
                if (!have || cand < best) begin
                    best = cand;
                    have = 1'b1;
                end
            end
            if (have) begin
                delta = longint'(off) * SecPerDay + longint'(best) * SecPerMin
                        - (longint'(mn) * SecPerMin + longint'(sc));
                if (delta < 0) delta = 0;
                res.found = 1'b1;
                res.day = off[DayW-1:0];
                res.minute = best[MinW-1:0];
                res.sleep = delta[SecW-1:0];
                return res;
            end
        end
        return res;
    endfunction

    // receiver stalls in random bursts
    always @(posedge i_clk) begin
        if (!calm && stall_left == 0 && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(1, 16);
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= (stall_left == 1);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // result check, sampled mid-cycle ahead of the accepting edge
    always @(negedge i_clk) begin
        t_wake exp_w;
        t_wake got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_found, o_day_offset, o_wake_minute, o_sleep_seconds};
            results_seen++;
            if (o_found) found_seen++;
            if (wake_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                exp_w = wake_q.pop_front();
                if (got !== exp_w) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", exp_w, got);
                end
            end
        end
    end

    // one request, held until accepted
    task automatic send_req(logic [2:0] wd, logic [MinW-1:0] mn, logic [5:0] sc);
        i_in_valid <= 1'b1;
        i_current_weekday <= wd;
        i_current_minute <= mn;
        i_current_second <= sc;
        do @(negedge i_clk); while (!o_in_ready);
        @(posedge i_clk);
        wake_q.push_back(predict_wakeup(wd, mn, sc));
        requests_sent++;
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (wake_q.size() != 0) @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // config writes, only while idle
    task automatic load_segs(logic [RegW-1:0] vals [NumSegRegs]);
        for (int i = 0; i < NumSegRegs; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= i[IdxW-1:0];
            i_cfg_data <= vals[i];
            sched_regs[i] = vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [RegW-1:0] pack_seg(bit en, logic [6:0] mask,
            int unsigned st, int unsigned fin, int unsigned iv);
        return {iv[10:0], fin[10:0], st[10:0], mask, en};
    endfunction

    function automatic logic [RegW-1:0] rand_seg();
        logic [RegW-1:0] v;
        int unsigned iv;
        int unsigned st;
        if ($urandom_range(0, 9) == 0) begin
            v = RegW'({$urandom, $urandom});
            return v;
        end
        st = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 1439);
        case ($urandom_range(0, 3))
            0: iv = 0;
            1: iv = $urandom_range(1, 60);
            2: iv = $urandom_range(1, 400);
            default: iv = $urandom_range(0, 2047);
        endcase
        return pack_seg($urandom_range(0, 7) != 0, 7'($urandom), st,
                        ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                                    : $urandom_range(0, 1439), iv);
    endfunction

    task automatic send_rand();
        logic [2:0] wd;
        logic [MinW-1:0] mn;
        logic [5:0] sc;
        wd = ($urandom_range(0, 9) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
        mn = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 2047))
                                         : 11'($urandom_range(0, 1439));
        sc = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                         : 6'($urandom_range(0, 59));
        send_req(wd, mn, sc);
    endtask

    // after reset no segment is set, so nothing is found
    task automatic test_reset_empty();
        send_req(3'd0, 11'd0, 6'd0);
        send_req(3'd7, 11'd2047, 6'd63);
        drain();
    endtask

    task automatic test_directed();
        logic [RegW-1:0] v [NumSegRegs];
        // interval steps, zero interval, end before start in both forms
        v[0] = pack_seg(1'b1, 7'h7f, 480, 600, 30);
        v[1] = pack_seg(1'b1, 7'h01, 700, 700, 0);
        v[2] = pack_seg(1'b1, 7'h02, 900, 890, 20);
        v[3] = pack_seg(1'b1, 7'h04, 900, 800, 20);
        v[4] = pack_seg(1'b0, 7'h7f, 10, 20, 5);
        v[5] = pack_seg(1'b1, 7'h40, 1500, 2047, 2047);
        v[6] = pack_seg(1'b1, 7'h08, 0, 1439, 1);
        v[7] = pack_seg(1'b1, 7'h00, 100, 200, 10);
        load_segs(v);
        send_req(3'd0, 11'd0, 6'd0);
        send_req(3'd0, 11'd480, 6'd59);
        send_req(3'd0, 11'd599, 6'd30);
        send_req(3'd0, 11'd600, 6'd0);
        send_req(3'd0, 11'd699, 6'd0);
        send_req(3'd1, 11'd850, 6'd10);
        send_req(3'd2, 11'd850, 6'd10);
        send_req(3'd3, 11'd1438, 6'd63);
        send_req(3'd3, 11'd2047, 6'd63);
        send_req(3'd6, 11'd1439, 6'd59);
        send_req(3'd7, 11'd1000, 6'd0);
        send_req(3'd5, 11'd1200, 6'd1);
        drain();
        // only a later day applies
        v = '{default: '0};
        v[3] = pack_seg(1'b1, 7'h10, 5, 10, 1);
        load_segs(v);
        send_req(3'd4, 11'd20, 6'd0);
        send_req(3'd5, 11'd0, 6'd0);
        send_req(3'd7, 11'd0, 6'd0);
        drain();
        // every register at its top value
        v = '{default: {RegW{1'b1}}};
        load_segs(v);
        send_req(3'd0, 11'd0, 6'd0);
        send_req(3'd6, 11'd2046, 6'd63);
        send_req(3'd7, 11'd2047, 6'd63);
        drain();
    endtask

    task automatic test_random(int unsigned phases, int unsigned per_phase);
        logic [RegW-1:0] v [NumSegRegs];
        for (int p = 0; p < phases; p++) begin
            foreach (v[i]) v[i] = rand_seg();
            load_segs(v);
            repeat (per_phase) send_rand();
            drain();
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_current_weekday <= '0;
        i_current_minute <= '0;
        i_current_second <= '0;
        i_out_ready <= 1'b1;
        stall_left = 0;
        calm = 1'b0;
        cycles = 0;
        mismatches = 0;
        requests_sent = 0;
        results_seen = 0;
        found_seen = 0;
        sched_regs = '{default: '0};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_empty();
        test_directed();
        test_random(10, 150);
        calm = 1'b1;
        test_random(2, 100);
        $display("covered %0d requests, %0d results (%0d found) in %0d cycles",
                 requests_sent, results_seen, found_seen, cycles);
        if (mismatches == 0 && wake_q.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, wake_q.size());
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
